// ===== design/ascii_integer_parser_assert.svh =====
// ----------------------------------------------------------------------------
// ascii_integer_parser assertion macros
// shared concurrent assertion forms for the parser rtl
// ----------------------------------------------------------------------------
`ifndef ASCII_INTEGER_PARSER_ASSERT_SVH
`define ASCII_INTEGER_PARSER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define AIP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ascii_integer_parser assertion failed");

// next-cycle implication, disabled during reset
`define AIP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ascii_integer_parser assertion failed");

`endif

// ===== design/aip_pkg.sv =====
// ----------------------------------------------------------------------------
// aip_pkg
// types, constants and character helpers of the ascii integer parser
// ----------------------------------------------------------------------------
package aip_pkg;

	typedef logic [5:0] digit_t;
	typedef logic [2:0] phase_t;

	// parse phases
	localparam phase_t PH_WS     = 3'd0;
	localparam phase_t PH_SIGNED = 3'd1;
	localparam phase_t PH_ZERO   = 3'd2;
	localparam phase_t PH_XSEEN  = 3'd3;
	localparam phase_t PH_DIGITS = 3'd4;
	localparam phase_t PH_DONE   = 3'd5;

	// error codes
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_INVALID = 2'd1;
	localparam logic [1:0] ERR_RANGE   = 2'd2;

	// radix limits and resolved bases
	localparam logic [5:0] RADIX_AUTO = 6'd0;
	localparam logic [5:0] RADIX_ONE  = 6'd1;
	localparam logic [5:0] RADIX_MAX  = 6'd36;
	localparam logic [5:0] BASE_HEX   = 6'd16;
	localparam logic [5:0] BASE_DEC   = 6'd10;
	localparam logic [5:0] BASE_OCT   = 6'd8;

	// marks a byte that is no digit in any base
	localparam digit_t NO_DIGIT = 6'd63;

	// characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	localparam logic [31:0] INT_MIN = 32'h8000_0000;
	localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

	// digit value of a byte, letters of either case from ten up
	function automatic digit_t digit_of(input logic [7:0] c);
		digit_t d;
		d = NO_DIGIT;
		if (c >= CH_0 && c <= CH_9) begin
			d = 6'(c - CH_0);
		end else if (c >= CH_UA && c <= CH_UZ) begin
			d = 6'(c - CH_UA + 8'd10);
		end else if (c >= CH_LA && c <= CH_LZ) begin
			d = 6'(c - CH_LA + 8'd10);
		end
		return d;
	endfunction

	// tab, line feed, vertical tab, form feed, carriage return, space
	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

// ===== design/ascii_integer_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_integer_parser
// streaming signed 32-bit integer parser, one character per word
// ----------------------------------------------------------------------------
// usage:
//   s_* takes one string byte per word; tuser carries the radix, read on the
//   first word of a string only; tlast marks the final byte of the string.
//   a zero byte ends the string early, the rest up to tlast is dropped.
//   m_* gives one word per string, on its tlast word: value, end offset and
//   error code (0 none, 1 invalid radix or no digits, 2 out of range).
// timing:
//   a word is held in the input register, then parse state and result
//   register update from it; m_tvalid rises once the tlast word leaves the
//   input register. one word per cycle unless a tlast word waits on a
//   blocked result; accumulate is one 32x6 multiply, subtract, saturate.
// stall:
//   while a result waits on m_tready, non-last words keep flowing; a second
//   tlast word waits in the input register and s_tready drops.
// reset:
//   arst_n clears all control and parse state; the next word starts a string.
// ----------------------------------------------------------------------------
`include "ascii_integer_parser_assert.svh"

module ascii_integer_parser
	import aip_pkg::*;
#(
	parameter int MAX_LEN = 256,
	localparam int OFF_W = $clog2(MAX_LEN + 1),
	localparam int M_DATA_W = ((34 + OFF_W + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // [7:0] char_in
	input  logic [5:0]          s_tuser,   // [5:0] radix
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata    // value, end_offset, error_code, zero fill
);

	localparam logic signed [38:0] MIN39 = -39'sd2147483648;

	// input register
	logic             valid_s1;
	logic [7:0]       char_s1;
	logic [5:0]       radix_s1;
	logic             last_s1;

	// parse state
	phase_t           phase_q;
	logic [31:0]      acc_q;
	logic             neg_q;
	logic [5:0]       rad_q;
	logic [OFF_W-1:0] pos_q;
	logic [OFF_W-1:0] endm_q;
	logic [1:0]       err_q;
	logic             first_q;

	// result register
	logic             m_valid_q;
	logic [31:0]      value_q;
	logic [OFF_W-1:0] off_q;
	logic [1:0]       errc_q;

	// next state and result
	phase_t           ph;
	logic [31:0]      acc;
	logic             neg;
	logic [5:0]       rad;
	logic [OFF_W-1:0] pos;
	logic [OFF_W-1:0] endm;
	logic [1:0]       err;
	logic [31:0]      res_val;
	logic [OFF_W-1:0] res_off;
	logic [1:0]       res_err;

	logic             adv_s1;
	logic             fire_s1;

	// handshake: input register moves unless it holds a tlast word and a result is blocked
	assign adv_s1   = !last_s1 || !m_valid_q || m_tready;
	assign fire_s1  = valid_s1 && adv_s1;
	assign s_tready = !valid_s1 || adv_s1;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = M_DATA_W'({errc_q, off_q, value_q});

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1  <= s_tdata;
			radix_s1 <= s_tuser;
			last_s1  <= s_tlast;
		end
	end

	// parse one byte against the current state
	always_comb begin
		digit_t            dig;
		logic              start;
		logic              dphase;
		logic signed [38:0] prod;

		ph     = phase_q;
		acc    = acc_q;
		neg    = neg_q;
		rad    = rad_q;
		pos    = pos_q;
		endm   = endm_q;
		err    = err_q;
		start  = 1'b0;
		dphase = 1'b0;
		prod   = '0;
		dig    = digit_of(char_s1);

		// new string: fresh state and radix check
		if (first_q) begin
			ph   = PH_WS;
			acc  = '0;
			neg  = 1'b0;
			rad  = radix_s1;
			pos  = '0;
			endm = '0;
			err  = ERR_NONE;
			if (radix_s1 == RADIX_ONE || radix_s1 > RADIX_MAX) begin
				err = ERR_INVALID;
				ph  = PH_DONE;
			end
		end

		if (ph != PH_DONE) begin
			if (char_s1 == CH_NUL || pos >= OFF_W'(MAX_LEN)) begin
				ph = PH_DONE;
			end else begin
				unique case (ph)
					PH_WS: begin
						if (is_space(char_s1)) begin
							ph = PH_WS;
						end else if (char_s1 == CH_PLUS || char_s1 == CH_MINUS) begin
							neg = (char_s1 == CH_MINUS);
							ph  = PH_SIGNED;
						end else begin
							start = 1'b1;
						end
					end
					PH_SIGNED: start = 1'b1;
					PH_ZERO: begin
						if (char_s1 == CH_LX || char_s1 == CH_UX) begin
							ph = PH_XSEEN;
						end else begin
							if (rad == RADIX_AUTO) rad = BASE_OCT;
							dphase = 1'b1;
						end
					end
					PH_XSEEN: begin
						if (dig < BASE_HEX) begin
							rad    = BASE_HEX;
							dphase = 1'b1;
						end else begin
							ph = PH_DONE;
						end
					end
					PH_DIGITS: dphase = 1'b1;
					default:   ph = PH_DONE;
				endcase

				// first byte of the number: leading zero or base pick
				if (start) begin
					if (char_s1 == CH_0 && (rad == RADIX_AUTO || rad == BASE_HEX)) begin
						endm = pos + OFF_W'(1);
						ph   = PH_ZERO;
					end else begin
						if (rad == RADIX_AUTO) rad = BASE_DEC;
						dphase = 1'b1;
					end
				end

				// accumulate as a negative value, saturating at the minimum
				if (dphase) begin
					if (dig < rad) begin
						prod = 39'($signed(acc)) * $signed({33'd0, rad})
							- $signed({33'd0, dig});
						if (prod < MIN39) begin
							acc = INT_MIN;
							err = ERR_RANGE;
						end else begin
							acc = prod[31:0];
						end
						endm = pos + OFF_W'(1);
						ph   = PH_DIGITS;
					end else begin
						ph = PH_DONE;
					end
				end

				pos = pos + OFF_W'(1);
			end
		end

		// result from the updated state
		res_val = '0;
		res_off = '0;
		res_err = ERR_INVALID;
		if (err != ERR_INVALID && endm != '0) begin
			res_err = err;
			res_off = endm;
			if (neg) begin
				res_val = acc;
			end else if (acc == INT_MIN) begin
				res_val = INT_MAX;
				res_err = ERR_RANGE;
			end else begin
				res_val = 32'd0 - acc;
			end
		end
	end

	// parse state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WS;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			rad_q   <= '0;
			pos_q   <= '0;
			endm_q  <= '0;
			err_q   <= ERR_NONE;
			first_q <= 1'b1;
		end else if (fire_s1) begin
			phase_q <= ph;
			acc_q   <= acc;
			neg_q   <= neg;
			rad_q   <= rad;
			pos_q   <= pos;
			endm_q  <= endm;
			err_q   <= err;
			first_q <= last_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			value_q <= res_val;
			off_q   <= res_off;
			errc_q  <= res_err;
		end
	end

	// checks
	`AIP_ASSERT_IMP(a_invalid_zero, clk, arst_n, m_valid_q && errc_q == ERR_INVALID,
		value_q == '0 && off_q == '0)
	`AIP_ASSERT_IMP(a_ok_has_offset, clk, arst_n, m_valid_q && errc_q != ERR_INVALID,
		off_q != '0)
	`AIP_ASSERT_IMP(a_pos_bound, clk, arst_n, 1'b1, pos_q <= OFF_W'(MAX_LEN))
	`AIP_ASSERT_NXT(a_last_restarts, clk, arst_n, fire_s1 && last_s1, first_q && m_valid_q)
	`AIP_ASSERT_NXT(a_done_sticks, clk, arst_n, phase_q == PH_DONE && !first_q,
		phase_q == PH_DONE || first_q)

endmodule

// ===== bench/ascii_integer_parser_tb.sv =====
// ----------------------------------------------------------------------------
// ascii_integer_parser_tb
// self-checking bench of the streaming string-to-integer parser
// ----------------------------------------------------------------------------
// strings go in one byte per word, with the radix on tuser and tlast on the
// final byte. a short table of hand-picked strings comes first: overflow
// bounds, bad radix, empty and sign-only strings, hex and octal prefixes.
// random strings follow, mostly well formed, with noise and broken ones mixed
// in and a few that run past the length limit. a bit-exact parse model run on
// every accepted byte predicts each untyped result word; the result port is
// checked field by field against the oldest prediction. during the random
// strings both sides stall in random bursts, bar quiet stretches and the tail.
// ----------------------------------------------------------------------------
module ascii_integer_parser_tb;
	import aip_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STR_LIMIT   = 256;
	localparam int BYTE_TARGET = 1250;
	localparam int QUIET_AFTER = 1050;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 10;

	typedef struct packed {
		logic [31:0] value;
		logic [8:0]  offset;
		logic [1:0]  code;
	} parse_result_t;

	typedef struct {
		string         txt;
		int            nul_at;
		logic [5:0]    radix;
		bit            typed;
		parse_result_t res;
	} string_row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;   // [7:0] char_in
	logic [5:0]  s_tuser  = '0;   // [5:0] radix
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;         // [31:0] value, [40:32] end_offset, [42:41] error_code

	// parse model state
	phase_t      ps_phase;
	logic [31:0] ps_acc;
	logic        ps_neg;
	logic [5:0]  ps_base;
	int          ps_pos;
	int          ps_mark;
	logic [1:0]  ps_err;
	bit          ps_fresh;

	parse_result_t due_numbers[$];
	string_row_t   string_table[$];
	int            mismatches = 0;
	int            bytes_sent = 0;
	int            quiet_cycles = 0;
	int            stall_left = 0;
	bit            idle_on = 1'b0;

	ascii_integer_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// digit weight of a byte, 99 when it is no digit at all
	function automatic int char_value(input logic [7:0] c);
		if (c >= CH_0 && c <= CH_9) return int'(c) - int'(CH_0);
		if (c >= CH_UA && c <= CH_UZ) return int'(c) - int'(CH_UA) + 10;
		if (c >= CH_LA && c <= CH_LZ) return int'(c) - int'(CH_LA) + 10;
		return 99;
	endfunction

	// digit as a character, letters in random case
	function automatic logic [7:0] digit_char(input int v);
		if (v < 10) return CH_0 + 8'(v);
		return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(v - 10);
	endfunction

	function automatic void clear_parse();
		ps_phase = PH_WS;
		ps_acc   = '0;
		ps_neg   = 1'b0;
		ps_base  = RADIX_AUTO;
		ps_pos   = 0;
		ps_mark  = 0;
		ps_err   = ERR_NONE;
		ps_fresh = 1'b1;
	endfunction

	// accumulate a digit of the resolved base as a negative value, or stop
	function automatic void digit_step(input logic [7:0] c);
		int     d;
		longint a;
		d = char_value(c);
		if (d < int'(ps_base)) begin
			a = longint'($signed(ps_acc)) * longint'(ps_base) - longint'(d);
			if (a < -64'sd2147483648) begin
				a = -64'sd2147483648;
				ps_err = ERR_RANGE;
			end
			ps_acc = a[31:0];
			ps_mark = ps_pos + 1;
			ps_phase = PH_DIGITS;
		end else begin
			ps_phase = PH_DONE;
		end
	endfunction

	// first byte after blanks and sign
	function automatic void number_start(input logic [7:0] c);
		if (c == CH_0 && (ps_base == RADIX_AUTO || ps_base == BASE_HEX)) begin
			ps_mark = ps_pos + 1;
			ps_phase = PH_ZERO;
		end else begin
			if (ps_base == RADIX_AUTO) ps_base = BASE_DEC;
			digit_step(c);
		end
	endfunction

	// one accepted byte through the parse model; returns 1 with a result on tlast
	function automatic bit parse_byte(input logic [7:0] c, input logic [5:0] r,
			input logic lst, output parse_result_t res);
		res = '0;
		if (ps_fresh) begin
			clear_parse();
			ps_fresh = 1'b0;
			ps_base = r;
			if (r == RADIX_ONE || r > RADIX_MAX) begin
				ps_err = ERR_INVALID;
				ps_phase = PH_DONE;
			end
		end
		if (ps_phase != PH_DONE) begin
			if (c == CH_NUL || ps_pos >= STR_LIMIT) begin
				ps_phase = PH_DONE;
			end else begin
				case (ps_phase)
					PH_WS: begin
						if (c == CH_PLUS || c == CH_MINUS) begin
							ps_neg = (c == CH_MINUS);
							ps_phase = PH_SIGNED;
						end else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
							number_start(c);
						end
					end
					PH_SIGNED: number_start(c);
					PH_ZERO: begin
						if (c == CH_LX || c == CH_UX) begin
							ps_phase = PH_XSEEN;
						end else begin
							if (ps_base == RADIX_AUTO) ps_base = BASE_OCT;
							digit_step(c);
						end
					end
					PH_XSEEN: begin
						if (char_value(c) < int'(BASE_HEX)) begin
							ps_base = BASE_HEX;
							digit_step(c);
						end else begin
							ps_phase = PH_DONE;
						end
					end
					PH_DIGITS: digit_step(c);
					default: ps_phase = PH_DONE;
				endcase
				ps_pos++;
			end
		end
		if (!lst) return 1'b0;
		if (ps_err == ERR_INVALID || ps_mark == 0) begin
			res.code = ERR_INVALID;
		end else begin
			res.code = ps_err;
			res.offset = 9'(ps_mark);
			if (ps_neg) begin
				res.value = ps_acc;
			end else if (ps_acc == INT_MIN) begin
				res.value = INT_MAX;
				res.code = ERR_RANGE;
			end else begin
				res.value = -ps_acc;
			end
		end
		clear_parse();
		return 1'b1;
	endfunction

	function automatic void add_row(input string txt, input int nul_at, input logic [5:0] radix,
			input bit typed, input logic [31:0] v, input logic [8:0] off, input logic [1:0] code);
		string_row_t row;
		row.txt = txt;
		row.nul_at = nul_at;
		row.radix = radix;
		row.typed = typed;
		row.res = '{value: v, offset: off, code: code};
		string_table.push_back(row);
	endfunction

	function automatic void note_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
		end
	endfunction

	// send one string, predicting on every accepted byte
	task automatic send_text(input logic [7:0] str_bytes[$], input logic [5:0] radix,
			input bit typed, input parse_result_t typed_res);
		int            gap;
		bit            lst;
		logic [5:0]    r;
		parse_result_t got;
		foreach (str_bytes[i]) begin
			gap = (idle_on && $urandom_range(0, 9) == 0) ? $urandom_range(1, 17) : 0;
			lst = (i == str_bytes.size() - 1);
			// radix only counts on the first byte, so sometimes scramble it elsewhere
			r = (i > 0 && $urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : radix;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= str_bytes[i];
			s_tuser  <= r;
			s_tlast  <= lst;
			do @(posedge clk); while (!s_tready);
			if (parse_byte(str_bytes[i], r, lst, got))
				due_numbers.push_back(typed ? typed_res : got);
			bytes_sent++;
		end
	endtask

	// result check and receiver stalls
	always @(posedge clk) begin
		parse_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_numbers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result word with none expected: %0h", $realtime, m_tdata);
			end else begin
				want = due_numbers.pop_front();
				note_field("value", want.value, m_tdata[31:0]);
				note_field("end_offset", 32'(want.offset), 32'(m_tdata[40:32]));
				note_field("error_code", 32'(want.code), 32'(m_tdata[42:41]));
				note_field("zero fill", 32'd0, 32'(m_tdata[47:43]));
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 17) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog on cycles without any word moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		logic [7:0]    str_bytes[$];
		logic [5:0]    radix;
		int            base, sel, n, long_runs;
		bit            paused_mid;
		logic [7:0]    c;
		parse_result_t none;

		none = '0;
		long_runs = 0;
		paused_mid = 1'b0;
		clear_parse();

		// hand-picked strings, typed results where obvious
		add_row("7",            -1, 6'd10, 1, 32'd7,      9'd1,  ERR_NONE);
		add_row("2147483647",   -1, 6'd10, 1, INT_MAX,    9'd10, ERR_NONE);
		add_row("2147483648",   -1, 6'd10, 1, INT_MAX,    9'd10, ERR_RANGE);
		add_row("-2147483648",  -1, 6'd0,  1, INT_MIN,    9'd11, ERR_NONE);
		add_row("-99999999999", -1, 6'd0,  1, INT_MIN,    9'd12, ERR_RANGE);
		add_row("12",           -1, 6'd1,  1, 32'd0,      9'd0,  ERR_INVALID);
		add_row("5",            -1, 6'd63, 1, 32'd0,      9'd0,  ERR_INVALID);
		add_row("?",             0, 6'd10, 1, 32'd0,      9'd0,  ERR_INVALID);
		add_row("\t+",          -1, 6'd0,  1, 32'd0,      9'd0,  ERR_INVALID);
		add_row("+-5",          -1, 6'd10, 1, 32'd0,      9'd0,  ERR_INVALID);
		add_row("0xg",          -1, 6'd16, 1, 32'd0,      9'd1,  ERR_NONE);
		add_row("0x1F",         -1, 6'd0,  0, '0, '0, ERR_NONE);
		add_row("017",          -1, 6'd0,  0, '0, '0, ERR_NONE);
		add_row("08",           -1, 6'd0,  0, '0, '0, ERR_NONE);
		add_row("zZ",           -1, 6'd36, 0, '0, '0, ERR_NONE);
		add_row("101",          -1, 6'd2,  0, '0, '0, ERR_NONE);
		add_row("42.7",          2, 6'd10, 0, '0, '0, ERR_NONE);
		add_row("\n -0",        -1, 6'd0,  0, '0, '0, ERR_NONE);
		add_row("0x",           -1, 6'd10, 0, '0, '0, ERR_NONE);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (string_table[k]) begin
			str_bytes = {};
			for (int i = 0; i < string_table[k].txt.len(); i++)
				str_bytes.push_back(i == string_table[k].nul_at ? CH_NUL
					: 8'(string_table[k].txt[i]));
			send_text(str_bytes, string_table[k].radix, string_table[k].typed,
				string_table[k].res);
		end
		s_tvalid <= 1'b0;
		while (due_numbers.size() != 0) @(posedge clk);

		// random strings
		while (bytes_sent < BYTE_TARGET) begin
			idle_on = (bytes_sent < QUIET_AFTER) && ((bytes_sent / 150) % 3 != 2);
			if (!paused_mid && bytes_sent > 600) begin
				paused_mid = 1'b1;
				s_tvalid <= 1'b0;
				while (due_numbers.size() != 0) @(posedge clk);
			end
			str_bytes = {};
			sel = $urandom_range(0, 99);
			if (long_runs < 2 && bytes_sent > 300 && $urandom_range(0, 49) == 0) begin
				// past the length limit, digits all the way
				long_runs++;
				radix = BASE_DEC;
				n = $urandom_range(257, 300);
				repeat (n - 6) str_bytes.push_back(CH_0);
				repeat (6) str_bytes.push_back(digit_char($urandom_range(0, 9)));
			end else if (sel < 15) begin
				// noise
				radix = 6'($urandom_range(0, 63));
				repeat ($urandom_range(1, 8)) str_bytes.push_back(8'($urandom_range(0, 255)));
			end else begin
				// well formed number with random content
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6, 7: radix = RADIX_AUTO;
					8, 9, 10, 11:           radix = BASE_HEX;
					12, 13, 14:             radix = BASE_DEC;
					15, 16:                 radix = BASE_OCT;
					default:                radix = 6'($urandom_range(2, 36));
				endcase
				if ($urandom_range(0, 32) == 0)
					radix = $urandom_range(0, 1) ? RADIX_ONE : 6'($urandom_range(37, 63));
				base = (radix == RADIX_AUTO || radix == RADIX_ONE || radix > RADIX_MAX)
					? 10 : int'(radix);
				repeat ($urandom_range(0, 3)) begin
					n = $urandom_range(0, 5);
					str_bytes.push_back(n == 5 ? CH_SPACE : CH_TAB + 8'(n));
				end
				case ($urandom_range(0, 3))
					1: str_bytes.push_back(CH_PLUS);
					2: str_bytes.push_back(CH_MINUS);
					default: ;
				endcase
				n = $urandom_range(0, 9);
				if ((radix == RADIX_AUTO || radix == BASE_HEX) && n < 3) begin
					str_bytes.push_back(CH_0);
					str_bytes.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
					base = 16;
					if (n == 0) begin
						// prefix with no hex digit after it
						do c = 8'($urandom_range(1, 255)); while (char_value(c) < 16);
						str_bytes.push_back(c);
					end
				end else if (radix == RADIX_AUTO && n < 5) begin
					str_bytes.push_back(CH_0);
					base = 8;
				end
				n = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
				if (base == 2 && $urandom_range(0, 3) == 0) n = $urandom_range(30, 34);
				repeat (n) str_bytes.push_back(digit_char($urandom_range(0, base - 1)));
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3)) str_bytes.push_back(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 9) == 0)
					str_bytes.insert($urandom_range(0, str_bytes.size() - 1), CH_NUL);
				// broken sequences: cut short or one byte spoiled
				if (sel < 30) begin
					if ($urandom_range(0, 1))
						while (str_bytes.size() > $urandom_range(1, str_bytes.size()))
							void'(str_bytes.pop_back());
					else
						str_bytes[$urandom_range(0, str_bytes.size() - 1)] =
							8'($urandom_range(0, 255));
				end
			end
			send_text(str_bytes, radix, 1'b0, none);
		end

		// drain
		s_tvalid <= 1'b0;
		idle_on = 1'b0;
		while (due_numbers.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && due_numbers.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
